### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bat_pkg.sv
// ---------------------------------------------------------------------------
// bat_pkg
// type characters, result kinds and value helpers for the aux tag parser
// ---------------------------------------------------------------------------
package bat_pkg;

	// result kinds
	localparam logic [2:0] KIND_SCALAR  = 3'd0;
	localparam logic [2:0] KIND_CHAR    = 3'd1;
	localparam logic [2:0] KIND_STR_END = 3'd2;
	localparam logic [2:0] KIND_HEADER  = 3'd3;
	localparam logic [2:0] KIND_ELEM    = 3'd4;
	localparam logic [2:0] KIND_REC_END = 3'd5;

	// tag type characters
	localparam logic [7:0] TY_A   = 8'h41;
	localparam logic [7:0] TY_C_S = 8'h63; // 'c'
	localparam logic [7:0] TY_C_U = 8'h43; // 'C'
	localparam logic [7:0] TY_S_S = 8'h73; // 's'
	localparam logic [7:0] TY_S_U = 8'h53; // 'S'
	localparam logic [7:0] TY_I_S = 8'h69; // 'i'
	localparam logic [7:0] TY_I_U = 8'h49; // 'I'
	localparam logic [7:0] TY_F   = 8'h66;
	localparam logic [7:0] TY_Z   = 8'h5A;
	localparam logic [7:0] TY_H   = 8'h48;
	localparam logic [7:0] TY_B   = 8'h42;
	localparam logic [7:0] NUL    = 8'h00;

	typedef logic signed [32:0] value_t;

	// bytes taken by a scalar value, zero for anything unknown
	function automatic logic [2:0] scalar_size(input logic [7:0] t);
		case (t)
			TY_A, TY_C_S, TY_C_U: scalar_size = 3'd1;
			TY_S_S, TY_S_U:       scalar_size = 3'd2;
			TY_I_S, TY_I_U, TY_F: scalar_size = 3'd4;
			default:              scalar_size = 3'd0;
		endcase
	endfunction

	// bytes taken by one array element, zero for anything unknown
	function automatic logic [2:0] element_size(input logic [7:0] t);
		case (t)
			TY_C_S, TY_C_U:       element_size = 3'd1;
			TY_S_S, TY_S_U:       element_size = 3'd2;
			TY_I_S, TY_I_U, TY_F: element_size = 3'd4;
			default:              element_size = 3'd0;
		endcase
	endfunction

	// sign or zero extension of a gathered little-endian value
	function automatic value_t extend(input logic [31:0] raw, input logic [7:0] t,
			input logic [2:0] size);
		logic sgn;
		sgn = (t == TY_C_S) || (t == TY_S_S) || (t == TY_I_S);
		case (size)
			3'd1:    extend = {{25{sgn & raw[7]}}, raw[7:0]};
			3'd2:    extend = {{17{sgn & raw[15]}}, raw[15:0]};
			3'd4:    extend = {sgn & raw[31], raw};
			default: extend = {1'b0, raw};
		endcase
	endfunction

endpackage

### design/bam_aux_tag_parser_top.sv
// ---------------------------------------------------------------------------
// bam_aux_tag_parser_top
// streaming parser for the auxiliary tag bytes of one alignment record
// ---------------------------------------------------------------------------
// Takes one tag byte per request on the input channel and gives results on
// the output channel: one per scalar, one per string character plus one at
// the string end, an array header plus one per array element, and a record
// end result on the byte flagged as the last of the record. A byte is
// parsed in the cycle it is accepted; its results (at most three) sit in an
// output register and leave one per cycle while the receiver takes them. A
// byte causing no result or one result does not hold the input, so a tag
// stream runs at one byte per cycle while the output side keeps up; a byte
// causing more results holds the input until the single result register
// has drained them one at a time. The input is still taken in the cycle the
// last pending result leaves. No clearing pass after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bam_aux_tag_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                record_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          kind,
	output logic [7:0]          key_first,
	output logic [7:0]          key_second,
	output logic [7:0]          type_code,
	output logic [7:0]          element_type,
	output bat_pkg::value_t     value,
	output logic                dropped,
	output logic                run_last
);
	import bat_pkg::*;

	// parser phases
	localparam logic [2:0] PH_KEY1   = 3'd0;
	localparam logic [2:0] PH_KEY2   = 3'd1;
	localparam logic [2:0] PH_TYPE   = 3'd2;
	localparam logic [2:0] PH_SCALAR = 3'd3;
	localparam logic [2:0] PH_STRING = 3'd4;
	localparam logic [2:0] PH_ELTYPE = 3'd5;
	localparam logic [2:0] PH_COUNT  = 3'd6;
	localparam logic [2:0] PH_ELEM   = 3'd7;

	// parser state
	logic [2:0]  phase_q;
	logic [7:0]  key1_q, key2_q, type_q, elt_q;
	logic [2:0]  pos_q;
	logic [31:0] acc_q;
	logic [31:0] rem_q;

	// next state before the record end clears it
	logic [2:0]  nx_phase;
	logic [7:0]  nx_key1, nx_key2, nx_type, nx_elt;
	logic [2:0]  nx_pos;
	logic [31:0] nx_acc;
	logic [31:0] nx_rem;

	// results of the byte being accepted
	logic [1:0]  res_n;
	logic [2:0]  res_kind [0:2];
	value_t      res_val;
	logic        drop;

	// gather helpers
	logic [2:0]  pos_g;
	logic [31:0] acc_g;
	logic [2:0]  sz;
	logic [31:0] rem_dec;

	// pending result bundle
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;
	logic [2:0]  okind_q [0:2];
	value_t      oval_q;
	logic [7:0]  okey1_q, okey2_q, otype_q, oelt_q;
	logic        odrop_q;

	logic        in_acc;
	logic        out_acc;
	logic        last_res;
	logic [2:0]  cur_kind;

	// next little-endian byte lands at the current position, ignored past four
	assign pos_g   = pos_q + 3'd1;
	assign acc_g   = pos_q[2] ? acc_q
		: (acc_q | ({24'd0, data_byte} << {pos_q[1:0], 3'b000}));
	assign rem_dec = rem_q - 32'd1;

	always_comb begin
		nx_phase = phase_q;
		nx_key1  = key1_q;
		nx_key2  = key2_q;
		nx_type  = type_q;
		nx_elt   = elt_q;
		nx_pos   = pos_q;
		nx_acc   = acc_q;
		nx_rem   = rem_q;
		res_n    = 2'd0;
		res_kind[0] = KIND_REC_END;
		res_kind[1] = KIND_REC_END;
		res_kind[2] = KIND_REC_END;
		res_val  = '0;
		drop     = 1'b0;
		sz       = 3'd0;

		case (phase_q)
			PH_KEY2: begin
				nx_key2  = data_byte;
				nx_phase = PH_TYPE;
				drop     = record_end;
			end
			PH_TYPE: begin
				nx_type = data_byte;
				nx_elt  = 8'd0;
				nx_pos  = 3'd0;
				nx_acc  = 32'd0;
				if (scalar_size(data_byte) != 3'd0) begin
					nx_phase = PH_SCALAR;
					drop     = record_end;
				end else if (data_byte == TY_Z || data_byte == TY_H) begin
					nx_phase = PH_STRING;
					// empty string cut by the record end
					if (record_end) begin
						res_kind[0] = KIND_STR_END;
						res_n       = 2'd1;
					end
				end else if (data_byte == TY_B) begin
					nx_phase = PH_ELTYPE;
					drop     = record_end;
				end else begin
					// unknown type: no result, back to the next key
					nx_phase = PH_KEY1;
				end
			end
			PH_SCALAR: begin
				sz     = scalar_size(type_q);
				nx_pos = pos_g;
				nx_acc = acc_g;
				if (pos_g >= sz) begin
					res_kind[0] = KIND_SCALAR;
					res_val     = extend(acc_g, type_q, sz);
					res_n       = 2'd1;
					nx_phase    = PH_KEY1;
				end else begin
					drop = record_end;
				end
			end
			PH_STRING: begin
				if (data_byte == NUL) begin
					res_kind[0] = KIND_STR_END;
					res_n       = 2'd1;
					nx_phase    = PH_KEY1;
				end else begin
					res_kind[0] = KIND_CHAR;
					res_val     = {25'd0, data_byte};
					res_n       = 2'd1;
					// string closed by the record end
					if (record_end) begin
						res_kind[1] = KIND_STR_END;
						res_n       = 2'd2;
					end
				end
			end
			PH_ELTYPE: begin
				nx_elt   = data_byte;
				nx_pos   = 3'd0;
				nx_acc   = 32'd0;
				nx_phase = PH_COUNT;
				drop     = record_end;
			end
			PH_COUNT: begin
				nx_pos = pos_g;
				nx_acc = acc_g;
				if (pos_g >= 3'd4) begin
					nx_rem      = acc_g;
					res_kind[0] = KIND_HEADER;
					res_val     = {1'b0, acc_g};
					res_n       = 2'd1;
					nx_pos      = 3'd0;
					nx_acc      = 32'd0;
					if (element_size(elt_q) == 3'd0 || acc_g == 32'd0) begin
						nx_phase = PH_KEY1;
					end else begin
						nx_phase = PH_ELEM;
						drop     = record_end;
					end
				end else begin
					drop = record_end;
				end
			end
			PH_ELEM: begin
				sz     = element_size(elt_q);
				nx_pos = pos_g;
				nx_acc = acc_g;
				if (pos_g >= sz) begin
					res_kind[0] = KIND_ELEM;
					res_val     = extend(acc_g, elt_q, sz);
					res_n       = 2'd1;
					nx_pos      = 3'd0;
					nx_acc      = 32'd0;
					nx_rem      = rem_dec;
					if (rem_dec == 32'd0 || sz == 3'd0) begin
						nx_phase = PH_KEY1;
					end else begin
						drop = record_end;
					end
				end else begin
					drop = record_end;
				end
			end
			default: begin
				nx_key1  = data_byte;
				nx_phase = PH_KEY2;
				drop     = record_end;
			end
		endcase

		// record end result always closes the run
		if (record_end) begin
			res_kind[res_n] = KIND_REC_END;
			res_n           = res_n + 2'd1;
		end
	end

	// handshakes
	assign out_valid = (cnt_q != 2'd0);
	assign last_res  = (idx_q == cnt_q - 2'd1);
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = !out_valid || (out_ready && last_res);
	assign in_acc    = in_valid && in_ready;

	// parser state, back to its reset values after each record end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY1;
			key1_q  <= 8'd0;
			key2_q  <= 8'd0;
			type_q  <= 8'd0;
			elt_q   <= 8'd0;
			pos_q   <= 3'd0;
			acc_q   <= 32'd0;
			rem_q   <= 32'd0;
		end else if (in_acc) begin
			if (record_end) begin
				phase_q <= PH_KEY1;
				key1_q  <= 8'd0;
				key2_q  <= 8'd0;
				type_q  <= 8'd0;
				elt_q   <= 8'd0;
				pos_q   <= 3'd0;
				acc_q   <= 32'd0;
				rem_q   <= 32'd0;
			end else begin
				phase_q <= nx_phase;
				key1_q  <= nx_key1;
				key2_q  <= nx_key2;
				type_q  <= nx_type;
				elt_q   <= nx_elt;
				pos_q   <= nx_pos;
				acc_q   <= nx_acc;
				rem_q   <= nx_rem;
			end
		end
	end

	// bundle control: fill on a producing byte, step through on each take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (in_acc && res_n != 2'd0) begin
			cnt_q <= res_n;
			idx_q <= 2'd0;
		end else if (out_acc) begin
			if (last_res) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// bundle payload, keys as they stand after this byte
	always_ff @(posedge clk) begin
		if (in_acc && res_n != 2'd0) begin
			okind_q[0] <= res_kind[0];
			okind_q[1] <= res_kind[1];
			okind_q[2] <= res_kind[2];
			oval_q     <= res_val;
			okey1_q    <= nx_key1;
			okey2_q    <= nx_key2;
			otype_q    <= nx_type;
			oelt_q     <= nx_elt;
			odrop_q    <= drop;
		end
	end

	// only the first result of a run carries a value
	assign cur_kind     = okind_q[idx_q];
	assign kind         = cur_kind;
	assign key_first    = (cur_kind == KIND_REC_END) ? 8'd0 : okey1_q;
	assign key_second   = (cur_kind == KIND_REC_END) ? 8'd0 : okey2_q;
	assign type_code    = (cur_kind == KIND_REC_END) ? 8'd0 : otype_q;
	assign element_type = (cur_kind == KIND_HEADER || cur_kind == KIND_ELEM) ? oelt_q : 8'd0;
	assign value        = (idx_q == 2'd0) ? oval_q : '0;
	assign dropped      = (cur_kind == KIND_REC_END) ? odrop_q : 1'b0;
	assign run_last     = last_res;

	// checks
	`ASSERT_IMPL(a_idx_in_run, out_valid, idx_q < cnt_q, "result index beyond its run")
	`ASSERT_IMPL(a_drop_on_end, out_valid && dropped, kind == KIND_REC_END,
		"dropped flag on a result other than record end")
	`ASSERT_NEXT(a_end_resets, in_acc && record_end,
		phase_q == PH_KEY1 && pos_q == 3'd0 && rem_q == 32'd0,
		"parser state not cleared after record end")
	`ASSERT_CLK(a_no_stall, !in_ready |-> out_valid, "input stalled with no result pending")

endmodule

### dv/tb_bam_aux_tag_parser_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_bam_aux_tag_parser_top
// self-checking bench for the streaming aux tag parser
// ---------------------------------------------------------------------------
// Feeds whole records of tag bytes through the request channel: a short
// directed set for the corner cases, then random records built mostly from
// well-formed tags with random content, some cut short and some pure noise.
// A scoreboard class predicts every result from the accepted bytes and
// checks each result that leaves the block, in order and field by field.
// ---------------------------------------------------------------------------

package aux_tag_check_pkg;
	import bat_pkg::*;

	typedef enum logic [3:0] {
		AWAIT_KEY_FIRST,
		AWAIT_KEY_SECOND,
		AWAIT_TYPE,
		IN_SCALAR,
		IN_STRING,
		AWAIT_ELEM_TYPE,
		IN_COUNT,
		IN_ELEMENTS
	} parse_phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  key_first;
		logic [7:0]  key_second;
		logic [7:0]  type_code;
		logic [7:0]  element_type;
		logic [32:0] value;
		logic        dropped;
		logic        run_last;
	} aux_result_t;

	function automatic int unsigned scalar_bytes(input logic [7:0] t);
		if (t == TY_A || t == TY_C_S || t == TY_C_U)
			return 1;
		if (t == TY_S_S || t == TY_S_U)
			return 2;
		if (t == TY_I_S || t == TY_I_U || t == TY_F)
			return 4;
		return 0;
	endfunction

	function automatic int unsigned element_bytes(input logic [7:0] t);
		if (t == TY_A)
			return 0;
		return scalar_bytes(t);
	endfunction

	// little-endian gather result widened to 33 bits
	function automatic logic [32:0] widen(input logic [31:0] raw, input logic [7:0] t,
			input int unsigned nbytes);
		logic [32:0] field_mask;
		logic [32:0] v;
		int unsigned nbits;
		nbits = nbytes * 8;
		field_mask = (33'd1 << nbits) - 33'd1;
		v = {1'b0, raw} & field_mask;
		if ((t == TY_C_S || t == TY_S_S || t == TY_I_S) && raw[nbits - 1])
			v = v | ~field_mask;
		return v;
	endfunction

	function automatic string describe(input aux_result_t r);
		return $sformatf("kind=%0d key=%h/%h type=%h elem=%h value=%h dropped=%b last=%b",
			r.kind, r.key_first, r.key_second, r.type_code, r.element_type, r.value,
			r.dropped, r.run_last);
	endfunction

	class aux_result_scoreboard;
		aux_result_t  expected_q[$];
		aux_result_t  step_q[$];
		int unsigned  mismatch_count;
		int unsigned  results_checked;
		int unsigned  bytes_noted;
		int unsigned  records_noted;
		int unsigned  dropped_records;
		int unsigned  kind_count[8];

		parse_phase_t phase;
		logic [7:0]   kf;
		logic [7:0]   ks;
		logic [7:0]   ty;
		logic [7:0]   et;
		logic [2:0]   pos;
		logic [31:0]  acc;
		logic [31:0]  remaining;

		function new();
			clear_state();
		endfunction

		function void clear_state();
			phase = AWAIT_KEY_FIRST;
			kf = 8'h00;
			ks = 8'h00;
			ty = 8'h00;
			et = 8'h00;
			pos = 3'd0;
			acc = 32'd0;
			remaining = 32'd0;
		endfunction

		function void take_byte(input logic [7:0] b);
			if (pos < 3'd4)
				acc = acc | (32'(b) << (8 * pos));
			pos = pos + 3'd1;
		endfunction

		function void stage_result(input logic [2:0] k, input bit keyed, input logic [7:0] elem,
				input logic [32:0] v, input logic drop);
			aux_result_t r;
			r.kind = k;
			r.key_first = keyed ? kf : 8'h00;
			r.key_second = keyed ? ks : 8'h00;
			r.type_code = keyed ? ty : 8'h00;
			r.element_type = elem;
			r.value = v;
			r.dropped = drop;
			r.run_last = 1'b0;
			step_q.insert(step_q.size(), r);
		endfunction

		// one accepted request byte: advance the parse and queue its results
		function void note_request(input logic [7:0] b, input logic last_byte);
			logic drop;
			int unsigned sz;
			drop = 1'b0;
			step_q.delete();
			bytes_noted++;
			case (phase)
				AWAIT_KEY_SECOND: begin
					ks = b;
					phase = AWAIT_TYPE;
					drop = last_byte;
				end
				AWAIT_TYPE: begin
					ty = b;
					et = 8'h00;
					pos = 3'd0;
					acc = 32'd0;
					if (scalar_bytes(b) != 0) begin
						phase = IN_SCALAR;
						drop = last_byte;
					end else if (b == TY_Z || b == TY_H) begin
						phase = IN_STRING;
						if (last_byte)
							stage_result(KIND_STR_END, 1'b1, 8'h00, 33'd0, 1'b0);
					end else if (b == TY_B) begin
						phase = AWAIT_ELEM_TYPE;
						drop = last_byte;
					end else begin
						phase = AWAIT_KEY_FIRST;
					end
				end
				IN_SCALAR: begin
					sz = scalar_bytes(ty);
					take_byte(b);
					if (pos >= sz) begin
						stage_result(KIND_SCALAR, 1'b1, 8'h00, widen(acc, ty, sz), 1'b0);
						phase = AWAIT_KEY_FIRST;
					end else begin
						drop = last_byte;
					end
				end
				IN_STRING: begin
					if (b == NUL) begin
						stage_result(KIND_STR_END, 1'b1, 8'h00, 33'd0, 1'b0);
						phase = AWAIT_KEY_FIRST;
					end else begin
						stage_result(KIND_CHAR, 1'b1, 8'h00, {25'd0, b}, 1'b0);
						if (last_byte)
							stage_result(KIND_STR_END, 1'b1, 8'h00, 33'd0, 1'b0);
					end
				end
				AWAIT_ELEM_TYPE: begin
					et = b;
					pos = 3'd0;
					acc = 32'd0;
					phase = IN_COUNT;
					drop = last_byte;
				end
				IN_COUNT: begin
					take_byte(b);
					if (pos >= 3'd4) begin
						remaining = acc;
						stage_result(KIND_HEADER, 1'b1, et, {1'b0, acc}, 1'b0);
						sz = element_bytes(et);
						pos = 3'd0;
						acc = 32'd0;
						if (sz == 0 || remaining == 32'd0) begin
							phase = AWAIT_KEY_FIRST;
						end else begin
							phase = IN_ELEMENTS;
							drop = last_byte;
						end
					end else begin
						drop = last_byte;
					end
				end
				IN_ELEMENTS: begin
					sz = element_bytes(et);
					take_byte(b);
					if (pos >= sz) begin
						stage_result(KIND_ELEM, 1'b1, et, widen(acc, et, sz), 1'b0);
						pos = 3'd0;
						acc = 32'd0;
						remaining = remaining - 32'd1;
						if (remaining == 32'd0)
							phase = AWAIT_KEY_FIRST;
						else
							drop = last_byte;
					end else begin
						drop = last_byte;
					end
				end
				default: begin
					kf = b;
					phase = AWAIT_KEY_SECOND;
					drop = last_byte;
				end
			endcase
			if (last_byte) begin
				stage_result(KIND_REC_END, 1'b0, 8'h00, 33'd0, drop);
				records_noted++;
				if (drop)
					dropped_records++;
				clear_state();
			end
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].run_last = 1'b1;
			foreach (step_q[i])
				expected_q.insert(expected_q.size(), step_q[i]);
		endfunction

		function void check_result(input aux_result_t got);
			aux_result_t want;
			results_checked++;
			kind_count[got.kind]++;
			if (expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result at %0t: %s", $realtime, describe(got));
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.key_first !== want.key_first
					|| got.key_second !== want.key_second || got.type_code !== want.type_code
					|| got.element_type !== want.element_type || got.value !== want.value
					|| got.dropped !== want.dropped || got.run_last !== want.run_last) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

module tb_bam_aux_tag_parser_top;
	import bat_pkg::*;
	import aux_tag_check_pkg::*;

	localparam int unsigned HOLD_CYCLES   = 60;
	localparam int unsigned RANDOM_BYTES  = 175;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 20;

	// receiver behaviour, drawn anew at random each time the current mode runs out
	typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} ready_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        record_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  key_first;
	logic [7:0]  key_second;
	logic [7:0]  type_code;
	logic [7:0]  element_type;
	value_t      value;
	logic        dropped;
	logic        run_last;

	aux_result_scoreboard results;

	// stimulus bookkeeping
	logic [7:0]   record_q[$];
	bit           record_open;
	int unsigned  burst_left;
	int unsigned  random_bytes;
	int unsigned  records_sent;
	int unsigned  cycle_count;

	// receiver bookkeeping
	bit           hold_req;
	int unsigned  hold_left;
	int unsigned  holds_done;
	int unsigned  mode_left;
	ready_style_t ready_mode;

	logic [7:0] scalar_types[8] = '{TY_A, TY_C_S, TY_C_U, TY_S_S, TY_S_U, TY_I_S, TY_I_U, TY_F};
	logic [7:0] array_types[7]  = '{TY_C_S, TY_C_U, TY_S_S, TY_S_U, TY_I_S, TY_I_U, TY_F};

	bam_aux_tag_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.record_end   (record_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.key_first    (key_first),
		.key_second   (key_second),
		.type_code    (type_code),
		.element_type (element_type),
		.value        (value),
		.dropped      (dropped),
		.run_last     (run_last)
	);

	always #5 clk = ~clk;

	// run guard: a hang anywhere ends here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycle_count, results.pending());
			$display("tb_bam_aux_tag_parser_top failed");
			$finish;
		end
	end

	// monitor: results are checked before the request of the same edge is noted,
	// a request never has a result out on the edge it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				results.check_result(aux_result_t'{kind, key_first, key_second, type_code,
					element_type, value, dropped, run_last});
			if (in_valid && in_ready)
				results.note_request(data_byte, record_end);
		end
	end

	// receiver: stall pattern of its own, plus long hold-offs on demand
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			holds_done++;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_style_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (ready_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
				default:   out_ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// offer one request byte, idling between bursts, and wait for it to be taken
	task automatic send_item(input logic [7:0] b, input logic last_byte);
		int unsigned gap;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap - 1) @(negedge clk);
			// mostly short bursts, now and then a long stretch with no idling
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		record_end <= last_byte;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic send_record();
		foreach (record_q[i])
			send_item(record_q[i], i == record_q.size() - 1);
		records_sent++;
	endtask

	// stop offering and let every awaited result come out
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (results.pending() != 0)
			@(posedge clk);
	endtask

	// append one byte to the record being built
	function automatic void add_byte(input logic [7:0] b);
		record_q.insert(record_q.size(), b);
	endfunction

	// value bytes lean towards the extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic bit known_type(input logic [7:0] t);
		return scalar_bytes(t) != 0 || t == TY_Z || t == TY_H || t == TY_B;
	endfunction

	// one well-formed tag with random key and content; an open array leaves
	// the record unfinished with elements still due
	task automatic append_tag();
		logic [7:0]  t;
		logic [7:0]  et;
		logic [31:0] count;
		int unsigned pick;
		int unsigned n_el;
		add_byte(8'($urandom));
		add_byte(8'($urandom));
		pick = $urandom_range(0, 13);
		if (pick < 8) begin
			t = scalar_types[pick];
			add_byte(t);
			repeat (scalar_bytes(t))
				add_byte(pick_byte());
		end else if (pick < 10) begin
			add_byte(pick == 8 ? TY_Z : TY_H);
			repeat ($urandom_range(0, 6))
				add_byte(8'($urandom_range(1, 255)));
			add_byte(NUL);
		end else if (pick < 13) begin
			add_byte(TY_B);
			if ($urandom_range(0, 3) == 0) begin
				// unknown element type: header only, any count
				do
					et = 8'($urandom);
				while (element_bytes(et) != 0);
				count = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 3));
			end else begin
				et = array_types[$urandom_range(0, 6)];
				count = $urandom_range(0, 4);
				if ($urandom_range(0, 7) == 0) begin
					count = 32'($urandom) | 32'h100;
					record_open = 1'b1;
				end
			end
			add_byte(et);
			for (int i = 0; i < 4; i++)
				add_byte(count[8 * i +: 8]);
			if (element_bytes(et) == 0)
				n_el = 0;
			else
				n_el = record_open ? $urandom_range(1, 3) : count;
			repeat (n_el)
				repeat (element_bytes(et))
					add_byte(pick_byte());
		end else begin
			do
				t = 8'($urandom);
			while (known_type(t));
			add_byte(t);
		end
	endtask

	// a record of one to four tags, sometimes cut short, sometimes noise
	task automatic random_record();
		int unsigned n_tags;
		int unsigned keep;
		record_q.delete();
		record_open = 1'b0;
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom));
		end else begin
			n_tags = $urandom_range(1, 4);
			repeat (n_tags)
				if (!record_open)
					append_tag();
			if (!record_open && record_q.size() > 1 && $urandom_range(0, 3) == 0) begin
				keep = $urandom_range(1, record_q.size() - 1);
				record_q = record_q[0:keep - 1];
			end
		end
		random_bytes += record_q.size();
		send_record();
	endtask

	initial begin
		results = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: most negative int, one-character string, unknown type,
		// array with unknown element type and the largest count
		record_q = '{"X", "I", TY_I_S, 8'h00, 8'h00, 8'h00, 8'h80,
			"Z", "S", TY_Z, "a", NUL,
			"U", "K", 8'h71,
			"B", "X", TY_B, 8'h78, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_record();
		// empty string whose type byte closes the record
		record_q = '{"E", "S", TY_Z};
		send_record();
		// lone stray key byte at the record end
		record_q = '{8'hFF};
		send_record();
		wait_drain();

		// random records; a long receiver hold-off early on while requests keep
		// coming, a full drain in the middle, another hold-off later
		while (random_bytes < RANDOM_BYTES) begin
			if (records_sent == 6 || records_sent == 14)
				hold_req = 1'b1;
			if (records_sent == 10)
				wait_drain();
			random_record();
		end

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d request bytes in %0d records, %0d with a discarded tag; %0d results",
			results.bytes_noted, results.records_noted, results.dropped_records,
			results.results_checked);
		$display("results by kind: scalar %0d char %0d str-end %0d header %0d elem %0d rec-end %0d",
			results.kind_count[KIND_SCALAR], results.kind_count[KIND_CHAR],
			results.kind_count[KIND_STR_END], results.kind_count[KIND_HEADER],
			results.kind_count[KIND_ELEM], results.kind_count[KIND_REC_END]);
		if (results.mismatch_count == 0 && results.pending() == 0) begin
			$display("tb_bam_aux_tag_parser_top passed");
		end else begin
			$display("%0d mismatches, %0d results never seen",
				results.mismatch_count, results.pending());
			$display("tb_bam_aux_tag_parser_top failed");
		end
		$finish;
	end

endmodule
